// ===== sv/ultrasonic_echo_ranger_assert.svh =====
// Assertion macros shared by the ranger modules.
`ifndef ULTRASONIC_ECHO_RANGER_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define UER_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("ultrasonic echo ranger: invariant violated");

// When the antecedent holds, the consequent must hold at the same edge.
`define UER_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ultrasonic echo ranger: implication violated");

`endif

// ===== sv/uer_pkg.sv =====
package uer_pkg;

   // Defaults for the top-level parameters.
   localparam int SAMPLES_DEFAULT    = 5;
   localparam int COUNT_BITS_DEFAULT = 16;

   // Fixed field widths and constants.
   localparam int TRIG_BITS  = 10;
   localparam int DIST_BITS  = 19;
   localparam int CM_DIVISOR = 58;
   localparam int FRAC_SCALE = 256;
   localparam logic [TRIG_BITS-1:0] TRIG_TICKS_RESET = 10'd20;

   // Measurement phase.
   typedef enum logic [1:0] {
      PH_IDLE,
      PH_TRIG,
      PH_WAIT,
      PH_MEAS
   } phase_type;

   // Commands from the sequencer to the distance accumulator.
   typedef struct packed {
      logic clear;
      logic incr;
   } acc_cmd_type;

   // Per-word status from the sequencer.
   typedef struct packed {
      logic trigger;
      logic busy;
      logic done;
   } step_res_type;

endpackage

// ===== sv/uer_in_reg.sv =====
module uer_in_reg (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic start_req,
   input  logic echo,
   input  logic step_en,
   output logic in_valid,
   output logic start_q,
   output logic echo_q
);

   logic valid_ff, valid_in;
   logic start_ff;
   logic echo_ff;

   // The register can take a word when empty or when its word moves on.
   assign req_tready = !valid_ff || step_en;

   always_comb begin
      valid_in = valid_ff;
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
      end else if (step_en) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         start_ff <= start_req;
         echo_ff  <= echo;
      end
   end

   assign in_valid = valid_ff;
   assign start_q  = start_ff;
   assign echo_q   = echo_ff;

endmodule

// ===== sv/uer_ctrl.sv =====
`include "ultrasonic_echo_ranger_assert.svh"

module uer_ctrl #(
   parameter int SAMPLES    = uer_pkg::SAMPLES_DEFAULT,
   parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step_en,
   input  logic                           start,
   input  logic                           echo,
   input  logic                           csr_wr_en,
   input  logic [uer_pkg::TRIG_BITS-1:0]  csr_wr_data,
   output uer_pkg::acc_cmd_type           acc_cmd,
   output uer_pkg::step_res_type          res
);

   localparam int ROUND_BITS = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
   localparam logic [ROUND_BITS-1:0] LAST_ROUND = ROUND_BITS'(SAMPLES - 1);
   localparam logic [COUNT_BITS-1:0] PW_MAX = {COUNT_BITS{1'b1}};

   uer_pkg::phase_type                phase_ff, phase_in;
   logic [uer_pkg::TRIG_BITS-1:0]     timer_ff, timer_in;
   logic [uer_pkg::TRIG_BITS-1:0]     trig_ticks_ff;
   logic [COUNT_BITS-1:0]             pw_ff, pw_in;
   logic [ROUND_BITS-1:0]             round_ff, round_in;
   logic                              done;
   uer_pkg::acc_cmd_type              cmd;

   // Trigger length register.
   always_ff @(posedge clock) begin
      if (reset) begin
         trig_ticks_ff <= uer_pkg::TRIG_TICKS_RESET;
      end else if (csr_wr_en) begin
         trig_ticks_ff <= csr_wr_data;
      end
   end

   // Next state for one tick.
   always_comb begin
      phase_in  = phase_ff;
      timer_in  = timer_ff;
      pw_in     = pw_ff;
      round_in  = round_ff;
      cmd       = '0;
      done      = 1'b0;
      unique case (phase_ff)
         uer_pkg::PH_IDLE: begin
            if (start) begin
               round_in  = '0;
               pw_in     = '0;
               timer_in  = uer_pkg::TRIG_BITS'(1);
               phase_in  = uer_pkg::PH_TRIG;
               cmd.clear = 1'b1;
            end
         end
         uer_pkg::PH_TRIG: begin
            if (timer_ff >= trig_ticks_ff) begin
               phase_in = uer_pkg::PH_WAIT;
            end else begin
               timer_in = timer_ff + 1'b1;
            end
         end
         uer_pkg::PH_WAIT: begin
            // The rise tick counts as the first tick of the width.
            if (echo) begin
               pw_in    = COUNT_BITS'(1);
               phase_in = uer_pkg::PH_MEAS;
               cmd.incr = 1'b1;
            end
         end
         uer_pkg::PH_MEAS: begin
            if (echo) begin
               if (pw_ff != PW_MAX) begin
                  pw_in    = pw_ff + 1'b1;
                  cmd.incr = 1'b1;
               end
            end else begin
               pw_in = '0;
               if (round_ff == LAST_ROUND) begin
                  done     = 1'b1;
                  round_in = '0;
                  phase_in = uer_pkg::PH_IDLE;
               end else begin
                  round_in = round_ff + 1'b1;
                  timer_in = uer_pkg::TRIG_BITS'(1);
                  phase_in = uer_pkg::PH_TRIG;
               end
            end
         end
         default: begin
            phase_in = uer_pkg::PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= uer_pkg::PH_IDLE;
         timer_ff <= '0;
         pw_ff    <= '0;
         round_ff <= '0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         timer_ff <= timer_in;
         pw_ff    <= pw_in;
         round_ff <= round_in;
      end
   end

   // Status is taken from the state after the tick.
   assign res.trigger   = (phase_in == uer_pkg::PH_TRIG);
   assign res.busy      = (phase_in != uer_pkg::PH_IDLE);
   assign res.done      = done;
   assign acc_cmd.clear = step_en && cmd.clear;
   assign acc_cmd.incr  = step_en && cmd.incr;

   // The trigger timer never sits at zero while the trigger is driven.
   `UER_ASSERT_IMPLY(a_timer_live, clock, reset, phase_ff == uer_pkg::PH_TRIG,
      timer_ff != '0)
   // A width is held only while an echo is being measured.
   `UER_ASSERT_IMPLY(a_pw_idle, clock, reset, phase_ff != uer_pkg::PH_MEAS, pw_ff == '0)
   `UER_ASSERT_IMPLY(a_pw_meas, clock, reset, phase_ff == uer_pkg::PH_MEAS, pw_ff != '0)

endmodule

// ===== sv/uer_dist.sv =====
`include "ultrasonic_echo_ranger_assert.svh"

module uer_dist #(
   parameter int SAMPLES    = uer_pkg::SAMPLES_DEFAULT,
   parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  uer_pkg::acc_cmd_type          acc_cmd,
   output logic [uer_pkg::DIST_BITS-1:0] distance
);

   // The running total of widths times 256 is kept as quotient and
   // remainder by 58*SAMPLES, so each counted tick adds 256 with one
   // compare and subtract, and the mean is the quotient itself.
   localparam int DIVISOR  = uer_pkg::CM_DIVISOR * SAMPLES;
   localparam int RB       = $clog2(DIVISOR);
   localparam int QB       = COUNT_BITS + 3;
   localparam int STEP_Q   = uer_pkg::FRAC_SCALE / DIVISOR;
   localparam int STEP_R   = uer_pkg::FRAC_SCALE % DIVISOR;
   localparam int CMP_BITS = (QB > uer_pkg::DIST_BITS) ? QB : uer_pkg::DIST_BITS;
   localparam logic [CMP_BITS-1:0] DIST_MAX = CMP_BITS'((1 << uer_pkg::DIST_BITS) - 1);

   logic [QB-1:0]       q_ff, q_in;
   logic [RB-1:0]       r_ff, r_in;
   logic [RB:0]         r_sum;
   logic                wrap;
   logic [CMP_BITS-1:0] q_ext;

   // Add one tick worth of 256 to the quotient and remainder.
   always_comb begin
      r_sum = {1'b0, r_ff} + (RB + 1)'(STEP_R);
      wrap  = (r_sum >= (RB + 1)'(DIVISOR));
      r_in  = wrap ? RB'(r_sum - (RB + 1)'(DIVISOR)) : RB'(r_sum);
      q_in  = q_ff + QB'(STEP_Q) + QB'(wrap);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff <= '0;
         r_ff <= '0;
      end else if (acc_cmd.clear) begin
         q_ff <= '0;
         r_ff <= '0;
      end else if (acc_cmd.incr) begin
         q_ff <= q_in;
         r_ff <= r_in;
      end
   end

   // Saturate the mean to the output width.
   assign q_ext    = CMP_BITS'(q_ff);
   assign distance = (q_ext > DIST_MAX) ? uer_pkg::DIST_BITS'(DIST_MAX)
                                        : uer_pkg::DIST_BITS'(q_ext);

   // The remainder always stays below the divisor.
   `UER_ASSERT_ALWAYS(a_rem_range, clock, reset, r_ff < RB'(DIVISOR))

endmodule

// ===== sv/uer_out_reg.sv =====
module uer_out_reg (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_en,
   input  uer_pkg::step_res_type         res,
   input  logic [uer_pkg::DIST_BITS-1:0] distance,
   output logic                          can_load,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic                          trigger,
   output logic                          busy_res,
   output logic                          distance_valid,
   output logic [uer_pkg::DIST_BITS-1:0] distance_q
);

   logic                          valid_ff, valid_in;
   uer_pkg::step_res_type         res_ff;
   logic [uer_pkg::DIST_BITS-1:0] dist_ff;

   // A new word may load when the register is empty or being drained.
   assign can_load = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (step_en) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Distance reads zero except on the tick it is reported.
   always_ff @(posedge clock) begin
      if (step_en) begin
         res_ff  <= res;
         dist_ff <= res.done ? distance : '0;
      end
   end

   assign rsp_tvalid     = valid_ff;
   assign trigger        = res_ff.trigger;
   assign busy_res       = res_ff.busy;
   assign distance_valid = res_ff.done;
   assign distance_q     = dist_ff;

endmodule

// ===== sv/ultrasonic_echo_ranger.sv =====
// Ultrasonic echo ranger. Each request word is one microsecond tick carrying
// a start request and the sampled echo level; each tick returns exactly one
// response word with the trigger level, the busy flag and, on the tick that
// ends the last round, the mean distance in centimetres with 8 fraction bits
// (floor of total width * 256 / (58 * SAMPLES), saturated to 19 bits). A
// start seen while idle runs SAMPLES rounds of trigger pulse, wait for echo
// rise and echo width count; there is no echo timeout. A word passes through
// an input register and a response register with one tick of logic between
// them, so the block takes one word every clock cycle while rsp_tready is
// high; the mean is kept as a running quotient and remainder, which needs
// no divider. Write the trigger length through the csr port only while idle.
module ultrasonic_echo_ranger #(
   parameter int SAMPLES    = uer_pkg::SAMPLES_DEFAULT,
   parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [0] start_req, [1] echo
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [23:0]                   rsp_tdata,   // [0] trigger, [1] busy_res,
                                                      // [20:2] distance
   output logic                          rsp_tuser,   // [0] distance_valid
   input  logic                          csr_wr_en,
   input  logic [uer_pkg::TRIG_BITS-1:0] csr_wr_data
);

   logic                          in_valid;
   logic                          start_q;
   logic                          echo_q;
   logic                          can_load;
   logic                          step_en;
   uer_pkg::acc_cmd_type          acc_cmd;
   uer_pkg::step_res_type         res;
   logic [uer_pkg::DIST_BITS-1:0] distance;
   logic                          trigger;
   logic                          busy_res;
   logic                          distance_valid;
   logic [uer_pkg::DIST_BITS-1:0] distance_q;

   // A tick is processed when a word waits and the response slot is free.
   assign step_en = in_valid && can_load;

   uer_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .start_req  (req_tdata[0]),
      .echo       (req_tdata[1]),
      .step_en    (step_en),
      .in_valid   (in_valid),
      .start_q    (start_q),
      .echo_q     (echo_q)
   );

   uer_ctrl #(
      .SAMPLES    (SAMPLES),
      .COUNT_BITS (COUNT_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .step_en     (step_en),
      .start       (start_q),
      .echo        (echo_q),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .acc_cmd     (acc_cmd),
      .res         (res)
   );

   uer_dist #(
      .SAMPLES    (SAMPLES),
      .COUNT_BITS (COUNT_BITS)
   ) u_dist (
      .clock    (clock),
      .reset    (reset),
      .acc_cmd  (acc_cmd),
      .distance (distance)
   );

   uer_out_reg u_out_reg (
      .clock          (clock),
      .reset          (reset),
      .step_en        (step_en),
      .res            (res),
      .distance       (distance),
      .can_load       (can_load),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .trigger        (trigger),
      .busy_res       (busy_res),
      .distance_valid (distance_valid),
      .distance_q     (distance_q)
   );

   // Pack the response word.
   assign rsp_tdata = {3'b000, distance_q, busy_res, trigger};
   assign rsp_tuser = distance_valid;

endmodule
